FILE: sv/rcst_pkg.sv
// Shared types and constants of the radio-control channel framer.
package rcst_pkg;

    localparam int NUM_CHAN = 8;
    localparam int CHAN_W = 11;
    localparam int SW_W = 16;
    localparam int CNT_W = 16;
    localparam int SEQ_W = 8;
    localparam int STEP_W = 10;

    localparam logic [CHAN_W-1:0] TRIM_ON_LEVEL = 11'd1850;
    localparam logic [CHAN_W-1:0] TRIM_OFF_LEVEL = 11'd1700;
    localparam logic [CHAN_W-1:0] CHAN_MIN = 11'd1000;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 11'd1999;
    localparam logic [9:0] AXIS_SCALE = 10'd1000;
    localparam logic [15:0] AXIS_OFFSET = 16'h8000;
    localparam logic [CNT_W-1:0] DISCARD_MAX = 16'hFFFF;

    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 128;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        KIND_AXIS     = 2'd0,
        KIND_BTN_DOWN = 2'd1,
        KIND_BTN_UP   = 2'd2,
        KIND_TICK     = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIM_CHANNEL     = 3'd0,
        REG_ACTIVATE_CHANNEL = 3'd1,
        REG_TRIM_DIRECTION   = 3'd2,
        REG_TRIM_STEP        = 3'd3,
        REG_GLITCH_FIX       = 3'd4
    } cfg_idx_t;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        logic [CNT_W-1:0] discard_total;
        logic [SW_W-1:0] switch_bits;
        chan_t [NUM_CHAN-1:0] chans;
        logic [SEQ_W-1:0] sequence_res;
    } frame_data_t;

    typedef struct packed {
        logic frame_sent;
        frame_data_t data;
    } result_t;

    function automatic chan_t add_clamped(chan_t v, logic [STEP_W-1:0] step);
        logic [CHAN_W:0] r;
        r = {1'b0, v} + {2'b00, step};
        return (r > {1'b0, CHAN_MAX}) ? CHAN_MAX : r[CHAN_W-1:0];
    endfunction

    function automatic chan_t sub_clamped(chan_t v, logic [STEP_W-1:0] step);
        logic [CHAN_W:0] lim;
        logic [CHAN_W:0] d;
        lim = {2'b00, step} + {1'b0, CHAN_MIN};
        d = {1'b0, v} - {2'b00, step};
        return ({1'b0, v} < lim) ? CHAN_MIN : d[CHAN_W-1:0];
    endfunction

endpackage

FILE: sv/rc_channel_state_trim_framer_core.sv
// Radio-control channel framer: channel state, trim, glitch repair and frame output.
// The result of a tick is registered into the head output entry, or into the skid entry when the head is occupied.
// Throughput: one request per cycle while s_tready is high; state updates in the same cycle a request is taken.
// A two-entry output buffer lets requests flow while one result waits for m_tready.
// Reset (synchronous, aresetn low): channels and last valid values to CHANNEL_INITIAL,
// trim marks, switches, history and counters to zero, trim and activate channel to -1.
module rc_channel_state_trim_framer_core #(
    parameter int CHANNEL_INITIAL = 1500,
    parameter int SWITCH_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rcst_pkg::IN_DATA_W-1:0]  s_tdata,  // item_index[4:0], axis_value[20:5]
    input  logic [1:0]                      s_tuser,  // kind[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sequence_res[7:0], chan_one..chan_eight[95:8], switch_bits[111:96],
    // discard_total[127:112]
    output logic [rcst_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]                      m_tuser,  // frame_sent[0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcst_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rcst_pkg::*;

    localparam chan_t CH_INIT = CHAN_W'(CHANNEL_INITIAL);
    localparam logic [4:0] SW_LIMIT = 5'(SWITCH_BITS);
    localparam logic [SW_W-1:0] SW_MASK = SW_W'((32'd1 << SWITCH_BITS) - 32'd1);

    logic [3:0] trim_channel_reg;
    logic [3:0] activate_channel_reg;
    logic trim_direction_reg;
    logic [STEP_W-1:0] trim_step_reg;
    logic glitch_fix_reg;

    chan_t chan_reg [NUM_CHAN];
    chan_t chan_next [NUM_CHAN];
    chan_t last_valid_reg [NUM_CHAN];
    chan_t last_valid_next [NUM_CHAN];
    logic [NUM_CHAN-1:0] trim_applied_reg;
    logic [NUM_CHAN-1:0] trim_applied_next;
    logic [SW_W-1:0] switch_reg;
    logic [SW_W-1:0] switch_next;
    logic [SW_W-1:0] hist_reg [3];
    logic [SW_W-1:0] hist_next [3];
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic [CNT_W-1:0] discard_reg;
    logic [CNT_W-1:0] discard_next;

    result_t head_reg;
    result_t skid_reg;
    logic head_valid_reg;
    logic skid_valid_reg;

    logic in_accept;
    logic out_pop;
    logic push;
    result_t result;

    kind_t kind;
    logic [4:0] item_index;
    logic [15:0] axis_value;
    logic [25:0] axis_prod;
    chan_t axis_chan;
    chan_t chan_glitch [NUM_CHAN];
    logic trim_en;
    logic [2:0] tc;
    logic [2:0] ac;
    chan_t act_first;
    chan_t act_second;
    chan_t trim_v1;
    chan_t trim_v2;
    chan_t trim_v3;
    logic trim_ta1;
    logic apply_hit;
    logic undo_hit;
    logic stable;

    assign kind = kind_t'(s_tuser);
    assign item_index = s_tdata[4:0];
    assign axis_value = s_tdata[20:5];
    assign in_accept = s_tvalid && s_tready;
    assign out_pop = m_tvalid && m_tready;
    assign push = in_accept && (kind == KIND_TICK);
    assign s_tready = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = head_valid_reg;
    assign m_tdata = head_reg.data;
    assign m_tuser = head_reg.frame_sent;

    assign axis_prod = (axis_value ^ AXIS_OFFSET) * AXIS_SCALE;
    assign axis_chan = CHAN_W'(axis_prod[25:16]) + CHAN_MIN;

    assign trim_en = !trim_channel_reg[3] && !activate_channel_reg[3];
    assign tc = trim_channel_reg[2:0];
    assign ac = activate_channel_reg[2:0];

    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            chan_glitch[i] = (glitch_fix_reg && chan_reg[i] == CHAN_MIN) ?
                             last_valid_reg[i] : chan_reg[i];
        end
        act_first = chan_glitch[ac];
        trim_v1 = chan_glitch[tc];
        apply_hit = (act_first >= TRIM_ON_LEVEL) && !trim_applied_reg[tc];
        if (apply_hit) begin
            trim_v2 = trim_direction_reg ? add_clamped(trim_v1, trim_step_reg)
                                         : sub_clamped(trim_v1, trim_step_reg);
        end else begin
            trim_v2 = trim_v1;
        end
        trim_ta1 = trim_applied_reg[tc] || apply_hit;
        act_second = (ac == tc) ? trim_v2 : act_first;
        undo_hit = (act_second <= TRIM_OFF_LEVEL) && trim_ta1;
        if (undo_hit) begin
            trim_v3 = trim_direction_reg ? sub_clamped(trim_v2, trim_step_reg)
                                         : add_clamped(trim_v2, trim_step_reg);
        end else begin
            trim_v3 = trim_v2;
        end
    end

    assign stable = (hist_reg[0] == hist_reg[1]);

    always_comb begin
        chan_next = chan_reg;
        last_valid_next = last_valid_reg;
        trim_applied_next = trim_applied_reg;
        switch_next = switch_reg;
        hist_next = hist_reg;
        seq_next = seq_reg;
        discard_next = discard_reg;
        result = '0;
        if (in_accept) begin
            unique case (kind)
                KIND_AXIS: begin
                    if (item_index[4:3] == 2'b00) begin
                        chan_next[item_index[2:0]] = axis_chan;
                        trim_applied_next[item_index[2:0]] = 1'b0;
                    end
                end
                KIND_BTN_DOWN: begin
                    if (item_index < SW_LIMIT) begin
                        switch_next = (switch_reg | (SW_W'(1) << item_index[3:0])) & SW_MASK;
                        hist_next[0] = switch_next;
                    end
                end
                KIND_BTN_UP: begin
                    if (item_index < SW_LIMIT) begin
                        switch_next = switch_reg & ~(SW_W'(1) << item_index[3:0]) & SW_MASK;
                    end
                end
                KIND_TICK: begin
                    chan_next = chan_glitch;
                    if (glitch_fix_reg) begin
                        last_valid_next = chan_glitch;
                    end
                    if (trim_en) begin
                        chan_next[tc] = trim_v3;
                        trim_applied_next[tc] = trim_ta1 && !undo_hit;
                    end
                    hist_next[2] = hist_reg[1];
                    hist_next[1] = hist_reg[0];
                    if (stable) begin
                        result.frame_sent = 1'b1;
                        result.data.sequence_res = seq_reg;
                        for (int i = 0; i < NUM_CHAN; i++) begin
                            result.data.chans[i] = chan_next[i];
                        end
                        result.data.switch_bits = switch_reg;
                        result.data.discard_total = discard_reg;
                        hist_next[0] = switch_reg;
                    end else begin
                        if (discard_reg != DISCARD_MAX) begin
                            discard_next = discard_reg + CNT_W'(1);
                        end
                        result.data.discard_total = discard_next;
                    end
                    seq_next = seq_reg + SEQ_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trim_channel_reg <= 4'hF;
            activate_channel_reg <= 4'hF;
            trim_direction_reg <= 1'b0;
            trim_step_reg <= '0;
            glitch_fix_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TRIM_CHANNEL:     trim_channel_reg <= cfg_data[3:0];
                REG_ACTIVATE_CHANNEL: activate_channel_reg <= cfg_data[3:0];
                REG_TRIM_DIRECTION:   trim_direction_reg <= cfg_data[0];
                REG_TRIM_STEP:        trim_step_reg <= cfg_data[STEP_W-1:0];
                REG_GLITCH_FIX:       glitch_fix_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                chan_reg[i] <= CH_INIT;
                last_valid_reg[i] <= CH_INIT;
            end
            trim_applied_reg <= '0;
            switch_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                hist_reg[i] <= '0;
            end
            seq_reg <= '0;
            discard_reg <= '0;
        end else begin
            chan_reg <= chan_next;
            last_valid_reg <= last_valid_next;
            trim_applied_reg <= trim_applied_next;
            switch_reg <= switch_next;
            hist_reg <= hist_next;
            seq_reg <= seq_next;
            discard_reg <= discard_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_pop) begin
            if (skid_valid_reg) begin
                head_reg <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                head_valid_reg <= push;
                head_reg <= result;
            end
        end else if (!head_valid_reg) begin
            head_valid_reg <= push;
            head_reg <= result;
        end else if (push) begin
            skid_reg <= result;
            skid_valid_reg <= 1'b1;
        end
    end

    a_skid_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("Output skid entry is occupied while the head entry is empty.");

    a_discard_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> discard_reg >= $past(discard_reg))
        else $error("Discard count decreased.");

    a_discard_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[111:0] == '0))
        else $error("A discarded frame carries nonzero channel or switch data.");

    a_event_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && kind != KIND_TICK && !out_pop && !head_valid_reg) |=> !m_tvalid)
        else $error("A non-tick request produced a result.");

endmodule
